// ===== rtl/smavg_pkg.sv =====
// Shared types and constants for the six-axis moving-average filter.
// Used by every module under rtl; depends on nothing else.
package smavg_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int NUM_ACCEL = 3;
	localparam int NUM_GYRO  = 3;
	localparam int NUM_CH    = NUM_ACCEL + NUM_GYRO;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_X_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_Y_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_Z_OFFSET = 2'd2;

	typedef struct packed {
		logic                       fresh_sample;
		logic signed [SAMPLE_W-1:0] accel_x_in;
		logic signed [SAMPLE_W-1:0] accel_y_in;
		logic signed [SAMPLE_W-1:0] accel_z_in;
		logic signed [SAMPLE_W-1:0] rate_x_in;
		logic signed [SAMPLE_W-1:0] rate_y_in;
		logic signed [SAMPLE_W-1:0] rate_z_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_x_avg;
		logic signed [SAMPLE_W-1:0] accel_y_avg;
		logic signed [SAMPLE_W-1:0] accel_z_avg;
		logic signed [SAMPLE_W-1:0] rate_x_avg;
		logic signed [SAMPLE_W-1:0] rate_y_avg;
		logic signed [SAMPLE_W-1:0] rate_z_avg;
	} out_item_t;

endpackage

// ===== rtl/six_axis_moving_average.sv =====
// Top level of the six-axis moving-average filter.
// Depends on smavg_pkg, smavg_window and smavg_divide.
//
// Usage: each beat on the item channel (item_valid, item_stall, item) carries a
// fresh_sample flag and six signed 16-bit samples. A beat with fresh_sample set
// pushes the samples into six windows of WINDOW_DEPTH entries and updates the
// stored channel averages (sum over the window divided by the depth, truncated
// toward zero). Every beat, fresh or not, produces exactly one beat on the
// result channel (result_valid, result_stall, result): the three acceleration
// averages and the three rate averages minus the gyro offsets, wrapped to 16 bits.
// The user must write the offsets via cfg_we, cfg_index and cfg_data only while
// idle; the block does not enforce this. Writes to an index beyond the gyro z
// offset are ignored. Throughput: one item per cycle while the result is not
// stalled, set by the running-sum update in the window stage and the single
// reciprocal multiply per channel. A stalled result holds its beat; the three
// internal stages keep filling until they are all occupied, and only then is
// item_stall raised. Reset clears the windows, the averages, the offsets and
// all valid flags.
module six_axis_moving_average #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  smavg_pkg::in_item_t                 item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output smavg_pkg::out_item_t                result,
	input  logic                                cfg_we,
	input  logic [smavg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smavg_pkg::CFG_W-1:0]         cfg_data
);
	import smavg_pkg::*;

	localparam int MAG_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

	logic       valid_s1_q, valid_s2_q, valid_s3_q;
	in_item_t   item_s1;
	logic       fresh_s2, fresh_s3;
	logic       ready1, ready2, ready3, out_free;
	logic       adv1, adv2, adv3, accept;

	logic signed [SAMPLE_W-1:0]              samp     [NUM_CH];
	logic [MAG_W-1:0]                        mag_s2   [NUM_CH];
	logic                                    neg_s2   [NUM_CH];
	logic signed [SAMPLE_W-1:0]              quo_avg  [NUM_CH];
	logic signed [NUM_CH-1:0][SAMPLE_W-1:0]  avg_q;
	logic signed [NUM_CH-1:0][SAMPLE_W-1:0]  avg_new;
	logic signed [NUM_GYRO-1:0][CFG_W-1:0]   offset_q;
	logic signed [NUM_GYRO-1:0][SAMPLE_W-1:0] rate_out;

	// Each stage may take a beat when it is empty or its beat moves on.
	assign out_free = !result_valid || !result_stall;
	assign ready3   = !valid_s3_q || out_free;
	assign ready2   = !valid_s2_q || ready3;
	assign ready1   = !valid_s1_q || ready2;
	assign adv3     = valid_s3_q && out_free;
	assign adv2     = valid_s2_q && ready3;
	assign adv1     = valid_s1_q && ready2;
	assign accept   = item_valid && ready1;
	assign item_stall = !ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q   <= 1'b0;
			valid_s2_q   <= 1'b0;
			valid_s3_q   <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1_q <= 1'b1;
			end else if (adv1) begin
				valid_s1_q <= 1'b0;
			end
			if (adv1) begin
				valid_s2_q <= 1'b1;
			end else if (adv2) begin
				valid_s2_q <= 1'b0;
			end
			if (adv2) begin
				valid_s3_q <= 1'b1;
			end else if (adv3) begin
				valid_s3_q <= 1'b0;
			end
			if (adv3) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (adv1) begin
			fresh_s2 <= item_s1.fresh_sample;
		end
		if (adv2) begin
			fresh_s3 <= fresh_s2;
		end
	end

	assign samp[0] = item_s1.accel_x_in;
	assign samp[1] = item_s1.accel_y_in;
	assign samp[2] = item_s1.accel_z_in;
	assign samp[3] = item_s1.rate_x_in;
	assign samp[4] = item_s1.rate_y_in;
	assign samp[5] = item_s1.rate_z_in;

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
		smavg_window #(
			.WINDOW_DEPTH(WINDOW_DEPTH)
		) u_window (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(adv1 && item_s1.fresh_sample),
			.sample  (samp[ch]),
			.mag_s2  (mag_s2[ch]),
			.neg_s2  (neg_s2[ch])
		);

		smavg_divide #(
			.WINDOW_DEPTH(WINDOW_DEPTH)
		) u_divide (
			.clk   (clk),
			.enable(adv2),
			.mag_s2(mag_s2[ch]),
			.neg_s2(neg_s2[ch]),
			.avg   (quo_avg[ch])
		);

		assign avg_new[ch] = fresh_s3 ? quo_avg[ch] : avg_q[ch];
	end

	for (genvar g = 0; g < NUM_GYRO; g++) begin : g_rate
		assign rate_out[g] = avg_new[NUM_ACCEL + g] - offset_q[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (adv3 && fresh_s3) begin
			avg_q <= avg_new;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			result.accel_x_avg <= avg_new[0];
			result.accel_y_avg <= avg_new[1];
			result.accel_z_avg <= avg_new[2];
			result.rate_x_avg  <= rate_out[0];
			result.rate_y_avg  <= rate_out[1];
			result.rate_z_avg  <= rate_out[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GYRO_X_OFFSET: offset_q[0] <= cfg_data;
				CFG_GYRO_Y_OFFSET: offset_q[1] <= cfg_data;
				CFG_GYRO_Z_OFFSET: offset_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// A finished beat in the last stage moves out whenever the receiver is not stalling.
	a_s3_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3_q && !result_stall |=> result_valid)
		else $error("stage three beat did not reach the result register");

	// The stored averages change only when a fresh beat leaves the pipeline.
	a_avg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv3 && fresh_s3) |=> $stable(avg_q))
		else $error("channel averages changed without a fresh beat");

	// A new result always comes from an occupied last stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s3_q))
		else $error("result appeared without a beat in stage three");

	// The input is only held off when every stage is occupied.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1_q && valid_s2_q && valid_s3_q)
		else $error("input stalled while a stage was free");
`endif

endmodule

// ===== rtl/smavg_window.sv =====
// One channel's sample window with a running sum, producing the sum's magnitude and sign.
// Depends on smavg_pkg for the sample width.
module smavg_window #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   shift_en,
	input  logic signed [smavg_pkg::SAMPLE_W-1:0]                  sample,
	output logic [smavg_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0]    mag_s2,
	output logic                                                   neg_s2
);
	import smavg_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

	logic signed [SAMPLE_W-1:0] win_q [WINDOW_DEPTH];
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    sum_next;
	logic [SUM_W-1:0]           mag_next;

	// The oldest sample leaves the sum as the new one enters it.
	assign sum_next = sum_q + SUM_W'(sample) - SUM_W'(win_q[0]);
	assign mag_next = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (shift_en) begin
			for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW_DEPTH-1] <= sample;
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			mag_s2 <= mag_next;
			neg_s2 <= sum_next[SUM_W-1];
		end
	end

endmodule

// ===== rtl/smavg_divide.sv =====
// Divides a window-sum magnitude by the window depth with a reciprocal multiply.
// Depends on smavg_pkg for the sample width.
module smavg_divide #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                                                clk,
	input  logic                                                enable,
	input  logic [smavg_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] mag_s2,
	input  logic                                                neg_s2,
	output logic signed [smavg_pkg::SAMPLE_W-1:0]               avg
);
	import smavg_pkg::*;

	localparam int MAG_W   = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int SHIFT   = MAG_W + $clog2(WINDOW_DEPTH);
	localparam int RECIP_W = MAG_W + 1;
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam int QUO_W   = SAMPLE_W + 1;
	// Rounded-up reciprocal; with this many fraction bits the quotient is exact
	// over the whole magnitude range.
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((longint'(1) << SHIFT) + longint'(WINDOW_DEPTH) - 1) / WINDOW_DEPTH);

	logic [PROD_W-1:0] prod_s3;
	logic              neg_s3;
	logic [QUO_W-1:0]  quo;

	always_ff @(posedge clk) begin
		if (enable) begin
			prod_s3 <= PROD_W'(mag_s2) * PROD_W'(RECIP);
			neg_s3  <= neg_s2;
		end
	end

	assign quo = prod_s3[SHIFT +: QUO_W];
	// Dividing the magnitude and restoring the sign truncates toward zero.
	assign avg = neg_s3 ? SAMPLE_W'(-quo) : SAMPLE_W'(quo);

endmodule

// ===== sim/six_axis_average_checker.sv =====
// Checker for the six-axis moving-average filter: predicts every result beat and compares it.
// Depends on smavg_pkg; watches the item, result and register-write ports of the block.
`timescale 1ns / 1ps
module six_axis_average_checker #(
	parameter int DEPTH = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  smavg_pkg::in_item_t             item,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  smavg_pkg::out_item_t            result,
	input  logic                            cfg_we,
	input  logic [smavg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smavg_pkg::CFG_W-1:0]     cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import smavg_pkg::*;

	typedef logic signed [SAMPLE_W-1:0] lane_t;
	typedef lane_t lanes_t [NUM_CH];

	lane_t     window [NUM_CH][DEPTH];
	lane_t     average [NUM_CH];
	lane_t     gyro_bias [NUM_GYRO];
	out_item_t pending_averages [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic string lane_name(int ch);
		case (ch)
			0:       return "accel_x_avg";
			1:       return "accel_y_avg";
			2:       return "accel_z_avg";
			3:       return "rate_x_avg";
			4:       return "rate_y_avg";
			default: return "rate_z_avg";
		endcase
	endfunction

	function automatic lanes_t result_lanes(out_item_t r);
		lanes_t l;
		l[0] = r.accel_x_avg;
		l[1] = r.accel_y_avg;
		l[2] = r.accel_z_avg;
		l[3] = r.rate_x_avg;
		l[4] = r.rate_y_avg;
		l[5] = r.rate_z_avg;
		return l;
	endfunction

	// Shifts a beat into the windows if it is fresh and returns the averages the block must report.
	function automatic out_item_t next_averages(in_item_t it);
		lane_t     fresh [NUM_CH];
		int        sum;
		out_item_t r;
		fresh[0] = it.accel_x_in;
		fresh[1] = it.accel_y_in;
		fresh[2] = it.accel_z_in;
		fresh[3] = it.rate_x_in;
		fresh[4] = it.rate_y_in;
		fresh[5] = it.rate_z_in;
		if (it.fresh_sample) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				for (int i = 0; i < DEPTH - 1; i++)
					window[ch][i] = window[ch][i + 1];
				window[ch][DEPTH - 1] = fresh[ch];
				sum = 0;
				for (int i = 0; i < DEPTH; i++)
					sum += window[ch][i];
				// Integer division in SystemVerilog truncates toward zero, as required.
				average[ch] = lane_t'(sum / DEPTH);
			end
		end
		r.accel_x_avg = average[0];
		r.accel_y_avg = average[1];
		r.accel_z_avg = average[2];
		r.rate_x_avg  = average[3] - gyro_bias[0];
		r.rate_y_avg  = average[4] - gyro_bias[1];
		r.rate_z_avg  = average[5] - gyro_bias[2];
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		lanes_t    got_l;
		lanes_t    want_l;
		if (!arst_n) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				average[ch] = '0;
				for (int i = 0; i < DEPTH; i++)
					window[ch][i] = '0;
			end
			for (int g = 0; g < NUM_GYRO; g++)
				gyro_bias[g] = '0;
			pending_averages.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GYRO_X_OFFSET: gyro_bias[0] = cfg_data;
					CFG_GYRO_Y_OFFSET: gyro_bias[1] = cfg_data;
					CFG_GYRO_Z_OFFSET: gyro_bias[2] = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (pending_averages.size() == 0) begin
					report_mismatch($sformatf("result beat %h with no item waiting", result));
				end else begin
					want   = pending_averages.pop_front();
					got_l  = result_lanes(result);
					want_l = result_lanes(want);
					for (int ch = 0; ch < NUM_CH; ch++)
						if (got_l[ch] !== want_l[ch])
							report_mismatch($sformatf("%s is %0d, expected %0d",
								lane_name(ch), got_l[ch], want_l[ch]));
				end
			end
			if (item_valid && !item_stall)
				pending_averages.push_back(next_averages(item));
			outstanding <= pending_averages.size();
		end
	end

endmodule

// ===== sim/tb_six_axis_moving_average.sv =====
// Testbench top for the six-axis moving-average filter: clock, reset, stimulus and verdict.
// Depends on smavg_pkg, six_axis_moving_average and six_axis_average_checker.
`timescale 1ns / 1ps
module tb_six_axis_moving_average;
	import smavg_pkg::*;

	localparam int WINDOW_DEPTH = 10;
	localparam int LATENCY      = 3;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_BEATS  = 120;
	localparam int CYCLE_LIMIT  = 200000;
	// Index past the last offset register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 2'd3;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	in_item_t             item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	out_item_t            result;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 stall_on     = 1'b1;
	bit                   idle_on      = 1'b1;
	int                   mismatches;
	int                   outstanding;
	int                   cycle_count  = 0;

	six_axis_moving_average #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	six_axis_average_checker #(
		.DEPTH(WINDOW_DEPTH)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk)
		result_stall <= stall_on && ($urandom_range(99) < 29);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly full-range values, with the extremes and small values around zero mixed in
	// so that truncation of negative sums is hit often.
	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2, 3:    return 16'($urandom_range(40)) - 16'd20;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t uniform_beat(logic fresh, logic [SAMPLE_W-1:0] value);
		in_item_t b;
		b.fresh_sample = fresh;
		b.accel_x_in   = value;
		b.accel_y_in   = value;
		b.accel_z_in   = value;
		b.rate_x_in    = value;
		b.rate_y_in    = value;
		b.rate_z_in    = value;
		return b;
	endfunction

	function automatic in_item_t random_beat();
		in_item_t b;
		b.fresh_sample = ($urandom_range(99) < 80);
		b.accel_x_in   = random_sample();
		b.accel_y_in   = random_sample();
		b.accel_z_in   = random_sample();
		b.rate_x_in    = random_sample();
		b.rate_y_in    = random_sample();
		b.rate_z_in    = random_sample();
		return b;
	endfunction

	// Called at a clock edge; returns at the edge where the beat is taken.
	task automatic send_beat(in_item_t b);
		while (idle_on && $urandom_range(99) < 29) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= b;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic set_offsets(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y, logic [CFG_W-1:0] z);
		wait_drained();
		write_reg(CFG_GYRO_X_OFFSET, x);
		write_reg(CFG_GYRO_Y_OFFSET, y);
		write_reg(CFG_GYRO_Z_OFFSET, z);
		write_reg(CFG_INDEX_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Warm-up with zero offsets: a stale beat, then small negatives that must truncate
		// toward zero, then full windows of each extreme.
		send_beat(uniform_beat(1'b0, 16'hFFFF));
		send_beat(uniform_beat(1'b1, -16'sd15));
		send_beat(uniform_beat(1'b1, -16'sd1));
		repeat (WINDOW_DEPTH) send_beat(uniform_beat(1'b1, 16'h7FFF));
		repeat (WINDOW_DEPTH) send_beat(uniform_beat(1'b1, 16'h8000));
		send_beat(uniform_beat(1'b0, 16'h7FFF));

		for (int phase = 1; phase <= 4; phase++) begin
			case (phase)
				1: set_offsets(16'h8000, 16'h7FFF, 16'($urandom));
				2: set_offsets(16'h7FFF, 16'h8000, 16'h0001);
				3: set_offsets(16'($urandom), 16'($urandom), 16'($urandom));
				default: set_offsets(16'h0000, 16'h0000, 16'h0000);
			endcase
			// Averages still hold the most negative value here, so subtracting the offsets can wrap.
			if (phase == 1)
				send_beat(uniform_beat(1'b0, 16'h0000));
			// The second phase runs back to back with neither side holding off.
			idle_on  = (phase != 2);
			stall_on <= (phase != 2);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (phase == 3 && n == PHASE_BEATS / 2)
					wait_drained();
				send_beat(random_beat());
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
